// File: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared constants and types for quaternion to Euler angles
// Arctangent table (2^32 = full turn), widths, and the CORDIC cell types.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int QuatWidth     = 16;
   localparam int AngleWidth    = 16;
   localparam int AtanTableLen  = 24;
   localparam int CordicStages  = 16;
   // Vector width: products reach about 2^32 in magnitude with the Q28 one,
   // and CORDIC gain (~1.65) adds a bit; 36 bits signed is ample.
   localparam int VecWidth      = 36;
   localparam int AccWidth      = 32;
   // sqrt operand is below 2^57, root below 2^29
   localparam int SqWidth       = 58;
   localparam int RootWidth     = 29;

   localparam logic [AccWidth-1:0] QuarterTurn = 32'h4000_0000;

   typedef logic signed [VecWidth-1:0] vec_type;

   // One CORDIC lane as it moves from cell to cell.
   typedef struct packed {
      vec_type               x;
      vec_type               y;
      logic [AccWidth-1:0]   acc;
      logic                  zero;   // both inputs zero: result is 0
   } lane_type;

   function automatic logic [AccWidth-1:0] atan_entry(input int idx);
      logic [AccWidth-1:0] r;
      r = '0;
      case (idx)
         0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
         12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
         18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
         21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward y = 0 by atan(2^-STAGE) and registers the lane.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic               clock,
   input  logic               enable,
   input  qte_pkg::lane_type  lane_in,
   output qte_pkg::lane_type  lane_out
);

   localparam logic [qte_pkg::AccWidth-1:0] Atan = qte_pkg::atan_entry(STAGE);

   qte_pkg::lane_type lane_ff, lane_in_c;
   qte_pkg::vec_type  xs, ys;

   always_comb begin
      xs = lane_in.x >>> STAGE;
      ys = lane_in.y >>> STAGE;
      lane_in_c = lane_in;
      if (lane_in.y[qte_pkg::VecWidth-1]) begin
         lane_in_c.x   = lane_in.x - ys;
         lane_in_c.y   = lane_in.y + xs;
         lane_in_c.acc = lane_in.acc - Atan;
      end else begin
         lane_in_c.x   = lane_in.x + ys;
         lane_in_c.y   = lane_in.y - xs;
         lane_in_c.acc = lane_in.acc + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in_c;
      end
   end

   assign lane_out = lane_ff;

endmodule

// File: rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one step of a pipelined restoring square root
// Each cell settles one result bit (two operand bits) and registers.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [qte_pkg::SqWidth-1:0]         rem_in,
   input  logic [qte_pkg::SqWidth-1:0]         res_in,
   output logic [qte_pkg::SqWidth-1:0]         rem_out,
   output logic [qte_pkg::SqWidth-1:0]         res_out
);

   // bit = 4^(28-STEP)
   localparam int BitPos = 2 * (qte_pkg::RootWidth - 1 - STEP);
   localparam logic [qte_pkg::SqWidth-1:0] BitVal =
      qte_pkg::SqWidth'(1) << BitPos;

   logic [qte_pkg::SqWidth-1:0] rem_ff, res_ff, rem_c, res_c, trial;

   always_comb begin
      trial = res_in + BitVal;
      if (rem_in >= trial) begin
         rem_c = rem_in - trial;
         res_c = (res_in >> 1) + BitVal;
      end else begin
         rem_c = rem_in;
         res_c = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_c;
         res_ff <= res_c;
      end
   end

   assign rem_out = rem_ff;
   assign res_out = res_ff;

endmodule

// File: rtl/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2: pipelined two-argument arctangent
// Half-plane pre-rotation, a chain of CORDIC cells, rounding to 16 bits.
// ----------------------------------------------------------------------------
module qte_atan2 #(
   parameter int CORDIC_STAGES = qte_pkg::CordicStages
) (
   input  logic                              clock,
   input  logic                              enable,
   input  qte_pkg::vec_type                  y_in,
   input  qte_pkg::vec_type                  x_in,
   output logic [qte_pkg::AngleWidth-1:0]    angle_out
);

   localparam int N = (CORDIC_STAGES < qte_pkg::AtanTableLen) ?
                      CORDIC_STAGES : qte_pkg::AtanTableLen;

   qte_pkg::lane_type pre_c, pre_ff;
   qte_pkg::lane_type chain [N+1];
   logic [qte_pkg::AccWidth-1:0] rounded;

   always_comb begin
      pre_c.x    = x_in;
      pre_c.y    = y_in;
      pre_c.acc  = '0;
      pre_c.zero = (x_in == '0) && (y_in == '0);
      if (x_in[qte_pkg::VecWidth-1]) begin
         if (!y_in[qte_pkg::VecWidth-1]) begin
            pre_c.x   = y_in;
            pre_c.y   = -x_in;
            pre_c.acc = qte_pkg::QuarterTurn;
         end else begin
            pre_c.x   = -y_in;
            pre_c.y   = x_in;
            pre_c.acc = -qte_pkg::QuarterTurn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pre_ff <= pre_c;
      end
   end

   assign chain[0] = pre_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      qte_cordic_cell #(.STAGE(i)) u_cell (
         .clock    (clock),
         .enable   (enable),
         .lane_in  (chain[i]),
         .lane_out (chain[i+1])
      );
   end

   assign rounded   = chain[N].acc + 32'h0000_8000;
   assign angle_out = chain[N].zero ? '0 : rounded[31:16];

endmodule

// File: rtl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: unit quaternion to roll, pitch and yaw
// Fully pipelined; one quaternion per clock while rsp_tready keeps the pipe moving.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one quaternion per transfer: w, x, y, z, each signed
//   Q1.14. rsp_ channel returns negated roll, pitch and negated yaw as 16-bit
//   binary angles (32768 = pi), plus a gimbal-lock flag in rsp_tuser.
// Throughput: one transfer per cycle, sustained while the output is not stalled.
// Pipeline: stage 1 forms the products, stage 2 the sums, stage 3 the clamp
//   test and root operand, stages 4..32 run the pitch square root (29 root
//   bits) in parallel with a delay line, stage 33 is the half-plane
//   pre-rotation, then the three CORDIC chains of S cells run side by side,
//   S = min(CORDIC_STAGES, 24), and the output register follows.
// Stall: the pipe and output register advance together; when rsp_tready is
//   low and the output register is full, the whole pipe freezes and
//   req_tready drops. Nothing is lost.
// Reset: clears the valid bits of every stage; payload registers are not
//   reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top #(
   parameter int CORDIC_STAGES = qte_pkg::CordicStages
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // roll_angle, pitch_angle, yaw_angle
   output logic         rsp_tuser    // pitch_clamped
);

   localparam int N = (CORDIC_STAGES < qte_pkg::AtanTableLen) ?
                      CORDIC_STAGES : qte_pkg::AtanTableLen;
   localparam int RW = qte_pkg::RootWidth;
   localparam int VW = qte_pkg::VecWidth;
   // products, sums, root operand, RW sqrt cells, pre-rotation, N cells,
   // output register
   localparam int Depth = 3 + RW + 1 + N + 1;

   logic enable;
   logic [Depth-1:0] valid_ff;

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[Depth-2:0], req_tvalid};
      end
   end

   // stage 1: products (Q2.28)
   logic signed [15:0] qw, qx, qy, qz;
   assign qw = req_tdata[15:0];
   assign qx = req_tdata[31:16];
   assign qy = req_tdata[47:32];
   assign qz = req_tdata[63:48];

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff,
                       zz_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         wx_ff <= qw * qx;  yz_ff <= qy * qz;  xx_ff <= qx * qx;
         yy_ff <= qy * qy;  wy_ff <= qw * qy;  zx_ff <= qz * qx;
         wz_ff <= qw * qz;  xy_ff <= qx * qy;  zz_ff <= qz * qz;
      end
   end

   // stage 2: sums
   localparam logic signed [VW-1:0] OneQ28 = VW'(1) <<< 28;
   qte_pkg::vec_type sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sr_ff <= (VW'(wx_ff) + VW'(yz_ff)) <<< 1;
         cr_ff <= OneQ28 - ((VW'(xx_ff) + VW'(yy_ff)) <<< 1);
         sp_ff <= (VW'(wy_ff) - VW'(zx_ff)) <<< 1;
         sy_ff <= (VW'(wz_ff) + VW'(xy_ff)) <<< 1;
         cy_ff <= OneQ28 - ((VW'(yy_ff) + VW'(zz_ff)) <<< 1);
      end
   end

   // stage 3: pitch clamp test and square root operand (2^56 - sp^2)
   // sp*sp is up to 2^64 for odd inputs, but only used when |sp| < 2^28,
   // so a 29x29 unsigned square is enough.
   logic sp_clamp_c;
   logic [RW-1:0] sp_mag;
   logic [qte_pkg::SqWidth-1:0] sq_op_c, sq_op_ff;
   assign sp_clamp_c = (sp_ff >= OneQ28) || (sp_ff <= -OneQ28);
   assign sp_mag = sp_ff[VW-1] ? RW'(-sp_ff) : RW'(sp_ff);
   assign sq_op_c = sp_clamp_c ? '0 :
      (qte_pkg::SqWidth'(1) << 56) - qte_pkg::SqWidth'(sp_mag * sp_mag);

   logic [qte_pkg::SqWidth-1:0] rem_ch [RW+1];
   logic [qte_pkg::SqWidth-1:0] res_ch [RW+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_op_ff <= sq_op_c;
      end
   end
   assign rem_ch[0] = sq_op_ff;
   assign res_ch[0] = '0;

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      qte_sqrt_cell #(.STEP(i)) u_sq (
         .clock   (clock),
         .enable  (enable),
         .rem_in  (rem_ch[i]),
         .res_in  (res_ch[i]),
         .rem_out (rem_ch[i+1]),
         .res_out (res_ch[i+1])
      );
   end

   // delay line alongside the root: sr, cr, sp, sy, cy, clamp
   typedef struct packed {
      qte_pkg::vec_type sr, cr, sp, sy, cy;
      logic             clamp;
   } side_type;

   side_type side_ff [RW+1];
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= '{sr: sr_ff, cr: cr_ff, sp: sp_ff, sy: sy_ff, cy: cy_ff,
                         clamp: sp_clamp_c};
         for (int k = 1; k <= RW; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // clamp flag and sign travel with the CORDIC chain
   logic [N:0] clamp_ff, sign_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         clamp_ff <= {clamp_ff[N-1:0], side_ff[RW].clamp};
         sign_ff  <= {sign_ff[N-1:0], side_ff[RW].sp[VW-1]};
      end
   end

   logic [15:0] roll_a, pitch_a, yaw_a;
   qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .enable(enable), .y_in(side_ff[RW].sr),
      .x_in(side_ff[RW].cr), .angle_out(roll_a));
   qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .enable(enable), .y_in(side_ff[RW].sp),
      .x_in(VW'(res_ch[RW])), .angle_out(pitch_a));
   qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .enable(enable), .y_in(side_ff[RW].sy),
      .x_in(side_ff[RW].cy), .angle_out(yaw_a));

   logic [15:0] pitch_final;
   assign pitch_final = !clamp_ff[N] ? pitch_a :
                        (sign_ff[N] ? 16'hC000 : 16'h4000);

   // output register
   logic [47:0] data_ff;
   logic        user_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= {16'(-yaw_a), pitch_final, 16'(-roll_a)};
         user_ff <= clamp_ff[N];
      end
   end

   assign rsp_tvalid = valid_ff[Depth-1];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

   // a result that is stalled does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("stalled result changed");
   // clamped pitch is exactly plus or minus a quarter turn
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:16] == 16'h4000 ||
                                   rsp_tdata[31:16] == 16'hC000)
      else $error("clamped pitch not at quarter turn");
   // while stalled no input is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken during stall");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: quaternion to Euler angles
// Streams quaternions through the block with random gaps and back-pressure.
// Each result is checked against a fixed-point roll/pitch/yaw predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int NumRandom  = 1630;
   localparam int StallLimit = 3000;
   localparam int DrainWait  = 80;
   localparam int LongHold   = 200;

   // Arctangent of 2^-i, full turn = 2^32.
   localparam logic [31:0] AtanStep [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   typedef struct {
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
      logic        locked;
   } euler_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   logic [63:0] quat_queue[$];      // quaternions waiting to be offered
   euler_type   angle_queue[$];     // predicted angles, oldest first
   int          req_gap = 0, rsp_gap = 0, hold_left = 0;
   bit          req_took = 0, rsp_took = 0, hold_done = 0, no_idle = 0;
   int          sent = 0, received = 0, errors = 0, locks = 0, idle_cycles = 0;

   quaternion_to_euler_angles_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor(sqrt(v)), bit by bit
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC: atan2(y, x) as a 16-bit binary angle.
   function automatic logic [15:0] angle_of(longint y, longint x);
      logic [31:0] acc;
      longint      t, nx, ny;
      int          n;
      acc = '0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; acc = 32'h4000_0000;
         end else begin
            x = -y; y = t; acc = 32'hC000_0000;
         end
      end
      n = (qte_pkg::CordicStages < 24) ? qte_pkg::CordicStages : 24;
      for (int i = 0; i < n; i++) begin
         if (y < 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); acc = acc - AtanStep[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); acc = acc + AtanStep[i];
         end
         x = nx;
         y = ny;
      end
      acc = acc + 32'h8000;
      return acc[31:16];
   endfunction

   function automatic euler_type predict_angles(logic [63:0] q);
      longint    w, x, y, z, sr, cr, sp, sy, cy;
      euler_type e;
      w = longint'(signed'(q[15:0]));
      x = longint'(signed'(q[31:16]));
      y = longint'(signed'(q[47:32]));
      z = longint'(signed'(q[63:48]));
      sr = 2 * (w * x + y * z);
      cr = (64'sd1 <<< 28) - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = (64'sd1 <<< 28) - 2 * (y * y + z * z);
      e.roll = 16'd0 - angle_of(sr, cr);
      e.yaw  = 16'd0 - angle_of(sy, cy);
      if (sp >= (64'sd1 <<< 28) || sp <= -(64'sd1 <<< 28)) begin
         e.pitch  = (sp > 0) ? 16'h4000 : 16'hC000;
         e.locked = 1'b1;
      end else begin
         e.pitch  = angle_of(sp, longint'(root_floor((64'd1 << 56) - 64'(sp * sp))));
         e.locked = 1'b0;
      end
      return e;
   endfunction

   function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
      return {16'(z), 16'(y), 16'(x), 16'(w)};
   endfunction

   // append one quaternion to the pending list
   task automatic add_quat(logic [63:0] q);
      quat_queue.insert(quat_queue.size(), q);
   endtask

   // Random unit quaternion, scaled to Q1.14.
   function automatic logic [63:0] unit_quat();
      real c[4], n;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         c[i] = real'(int'($urandom_range(0, 65534)) - 32767);
         n = n + c[i] * c[i];
      end
      if (n < 1.0) return pack_quat(16384, 0, 0, 0);
      n = $sqrt(n);
      return pack_quat($rtoi(c[0] * 16384.0 / n), $rtoi(c[1] * 16384.0 / n),
                       $rtoi(c[2] * 16384.0 / n), $rtoi(c[3] * 16384.0 / n));
   endfunction

   // Near gimbal lock: w ~ +-y, x ~ -+z, so 2(wy - zx) sits around one.
   function automatic logic [63:0] lock_quat();
      int a, b, sg;
      a  = int'($urandom_range(11560, 11610));
      b  = int'($urandom_range(0, 40));
      sg = $urandom_range(0, 1) ? 1 : -1;
      return pack_quat(a, b, sg * a, -sg * b);
   endfunction

   // Request side: sample transfers at the rising edge, predict on accept.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         angle_queue.insert(angle_queue.size(), predict_angles(req_tdata));
         req_took = 1;
         sent++;
      end
      if (!reset && rsp_tvalid && rsp_tready) rsp_took = 1;
   end

   // Driver: changes on the falling edge, one assignment per signal.
   always @(negedge clock) begin
      logic nv;
      nv = req_tvalid;
      if (req_took) begin
         nv = 1'b0;
         req_took = 0;
      end
      if (!reset && !nv) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (quat_queue.size() > 0) begin
            req_tdata <= quat_queue.pop_front();
            nv = 1'b1;
            if (sent % 150 == 0) no_idle = $urandom_range(0, 2) == 0;
            req_gap = no_idle ? 0 : $urandom_range(0, 6);
         end
      end
      req_tvalid <= nv;
   end

   // Receiver: random stalls, plus one long hold to back up the pipe.
   always @(negedge clock) begin
      logic nr;
      nr = rsp_tready;
      if (rsp_took) begin
         rsp_took = 0;
         rsp_gap = no_idle ? 0 : $urandom_range(0, 6);
         if (rsp_gap > 0) nr = 1'b0;
      end
      if (!hold_done && received == 300) begin
         hold_done = 1;
         hold_left = LongHold;
      end
      if (reset) begin
         nr = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         nr = 1'b0;
      end else if (!nr) begin
         if (rsp_gap > 0) rsp_gap--;
         else nr = 1'b1;
      end
      rsp_tready <= nr;
   end

   // Checker: compare every result transfer with the oldest prediction.
   always @(posedge clock) begin
      euler_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (angle_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            e = angle_queue.pop_front();
            if (e.locked) locks++;
            if (rsp_tdata !== {e.yaw, e.pitch, e.roll} || rsp_tuser !== e.locked) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp roll %h pitch %h yaw %h lock %b, got %h %h %h %b",
                           e.roll, e.pitch, e.yaw, e.locked, rsp_tdata[15:0],
                           rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser);
            end
         end
      end
   end

   // Watchdog: cycles with no transfer on either side while work is open.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset ||
          hold_left > 0)
         idle_cycles = 0;
      else if (req_tvalid || angle_queue.size() > 0)
         idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("watchdog: no progress for %0d cycles", StallLimit);
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      int k;
      // identities, axes, half turns
      add_quat(pack_quat(16384, 0, 0, 0));
      add_quat(pack_quat(-16384, 0, 0, 0));
      add_quat(pack_quat(0, 16384, 0, 0));
      add_quat(pack_quat(0, 0, 16384, 0));
      add_quat(pack_quat(0, 0, 0, 16384));
      add_quat(pack_quat(0, -16384, -16384, -16384));
      // all-zero quaternion
      add_quat(pack_quat(0, 0, 0, 0));
      // gimbal lock both signs, and just short of it
      add_quat(pack_quat(11586, 0, 11586, 0));
      add_quat(pack_quat(11586, 0, -11586, 0));
      add_quat(pack_quat(11585, 0, 11585, 0));
      add_quat(pack_quat(0, 11586, 0, -11586));
      add_quat(pack_quat(16384, 0, 16384, 0));
      add_quat(pack_quat(16384, 0, -16384, 0));
      // field extremes, out of range; then quarter-turn roll and yaw, and an equal-part unit quaternion
      add_quat(pack_quat(32767, 32767, 32767, 32767));
      add_quat(pack_quat(-32768, -32768, -32768, -32768));
      add_quat(pack_quat(32767, -32768, 32767, -32768));
      add_quat(pack_quat(-32768, 32767, -32768, 32767));
      add_quat(pack_quat(11585, 11585, 0, 0));
      add_quat(pack_quat(11585, 0, 0, -11585));
      add_quat(pack_quat(8192, 8192, 8192, 8192));
      for (int i = 0; i < NumRandom; i++) begin
         k = $urandom_range(0, 99);
         if (k < 70)      add_quat(unit_quat());
         else if (k < 85) add_quat(lock_quat());
         else             add_quat({$urandom, $urandom});
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (quat_queue.size() == 0 && !req_tvalid);
      wait (angle_queue.size() == 0);
      repeat (DrainWait) @(posedge clock);

      $display("%0d quaternions sent, %0d angle sets checked, %0d in gimbal lock,",
               sent, received, locks);
      $display("directed axes and extremes plus random unit and raw inputs, one long stall");
      if (errors == 0 && angle_queue.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches, %0d predictions left over", errors, angle_queue.size());
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
